// ===== hw/rtl/rgb_grey_histogram_core_defines.svh =====
//------------------------------------------------------------------------------
// rgb_grey_histogram_core_defines
// Assertion macros shared by the histogram RTL. Each expects clk and rst in scope.
//------------------------------------------------------------------------------
`ifndef RGB_GREY_HISTOGRAM_CORE_DEFINES_SVH
`define RGB_GREY_HISTOGRAM_CORE_DEFINES_SVH

// same-cycle implication
`define RGH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RGH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rgh_pkg.sv =====
//------------------------------------------------------------------------------
// rgh_pkg
// Types and constants of the grey-level histogram core.
//------------------------------------------------------------------------------
package rgh_pkg;

  localparam int COMP_W      = 8;   // one color component
  localparam int GREY_W      = 8;
  localparam int CFG_W       = 9;
  localparam int BIN_W       = 6;   // bin index on the port
  localparam int CNT_W       = 21;  // bin count on the port
  localparam int SUM_W       = 15;  // 21r+72g+7b <= 25500
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 17;  // recip = ceil(2^17 / bin_size)

  localparam int W_RED   = 21;
  localparam int W_GREEN = 72;
  localparam int W_BLUE  = 7;

  // floor(sum/100) == (sum * 5243) >> 19 for sum < 25600
  localparam int GREY_MUL   = 5243;
  localparam int GREY_SHIFT = 19;
  localparam int GREY_TOP   = 255;

  localparam int BIN_SIZE_MIN   = 4;
  localparam int BIN_SIZE_MAX   = 256;
  localparam int BIN_SIZE_RESET = 16;

  typedef struct packed {
    logic               busy;      // divider running, recip not usable
    logic [RECIP_W-1:0] recip;
    logic [BIN_W-1:0]   last_bin;  // highest bin index in use
  } rgh_recip_t;

  typedef struct packed {
    logic             busy;   // any pixel in flight
    logic             valid;  // bin below is live
    logic [BIN_W-1:0] bin;
  } rgh_bin_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_RUN,
    ST_FLUSH,
    ST_DUMP_RD,
    ST_DUMP_LD
  } rgh_state_t;

endpackage

// ===== hw/rtl/rgh_ram.sv =====
//------------------------------------------------------------------------------
// rgh_ram
// Simple dual-port RAM, one write and one read port, registered read (read-first).
//------------------------------------------------------------------------------
module rgh_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/rgh_recip.sv =====
//------------------------------------------------------------------------------
// rgh_recip
// Holds the bin width; on each write works out ceil(2^17/size) one bit per cycle,
// then the top bin index in use.
//------------------------------------------------------------------------------
module rgh_recip #(
  parameter int MAX_BINS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [rgh_pkg::CFG_W-1:0] cfg_wdata,
  output rgh_pkg::rgh_recip_t      rc
);
  import rgh_pkg::*;

  localparam int NUM_W = RECIP_SHIFT + 1;
  localparam logic [6:0] TOP_BIN = 7'(MAX_BINS - 1);

  logic [CFG_W-1:0]   s_eff;
  logic [CFG_W-1:0]   div;
  logic [NUM_W-1:0]   num;
  logic [7:0]         rem;
  logic [CFG_W-1:0]   rem_sh;
  logic               qbit;
  logic [RECIP_W-1:0] quo;
  logic [4:0]         cnt;
  logic               busy;
  logic [RECIP_W-1:0] recip;
  logic [BIN_W-1:0]   last_bin;
  logic [23:0]        top_prod;
  logic [6:0]         top_raw;

  always_comb begin
    if (cfg_wdata < CFG_W'(BIN_SIZE_MIN)) begin
      s_eff = CFG_W'(BIN_SIZE_MIN);
    end else if (cfg_wdata > CFG_W'(BIN_SIZE_MAX)) begin
      s_eff = CFG_W'(BIN_SIZE_MAX);
    end else begin
      s_eff = cfg_wdata;
    end
  end

  assign rem_sh   = {rem, num[NUM_W-1]};
  assign qbit     = (rem_sh >= div);
  assign top_prod = 24'(quo) * 24'(GREY_TOP);
  assign top_raw  = top_prod[RECIP_SHIFT +: 7];

  always_ff @(posedge clk) begin
    if (rst) begin
      div  <= CFG_W'(BIN_SIZE_RESET);
      num  <= NUM_W'(2 ** RECIP_SHIFT + BIN_SIZE_RESET - 1);
      rem  <= '0;
      quo  <= '0;
      cnt  <= 5'(NUM_W);
      busy <= 1'b1;
    end else if (cfg_we) begin
      div  <= s_eff;
      num  <= NUM_W'(2 ** RECIP_SHIFT) + NUM_W'(s_eff) - NUM_W'(1);
      rem  <= '0;
      quo  <= '0;
      cnt  <= 5'(NUM_W);
      busy <= 1'b1;
    end else if (busy) begin
      if (cnt != '0) begin
        num <= {num[NUM_W-2:0], 1'b0};
        rem <= qbit ? 8'(rem_sh - div) : rem_sh[7:0];
        quo <= {quo[RECIP_W-2:0], qbit};
        cnt <= cnt - 5'd1;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  // result registers load on the closing cycle of a run
  always_ff @(posedge clk) begin
    if (busy && cnt == '0 && !cfg_we) begin
      recip    <= quo;
      last_bin <= (top_raw > TOP_BIN) ? BIN_W'(TOP_BIN) : BIN_W'(top_raw);
    end
  end

  assign rc.busy     = busy;
  assign rc.recip    = recip;
  assign rc.last_bin = last_bin;

endmodule

// ===== hw/rtl/rgh_pixpipe.sv =====
//------------------------------------------------------------------------------
// rgh_pixpipe
// Three-stage pixel path: weighted sum, grey level, bin index.
//------------------------------------------------------------------------------
module rgh_pixpipe #(
  parameter int MAX_BINS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [rgh_pkg::COMP_W-1:0]  red,
  input  logic [rgh_pkg::COMP_W-1:0]  green,
  input  logic [rgh_pkg::COMP_W-1:0]  blue,
  input  logic [rgh_pkg::RECIP_W-1:0] recip,
  output rgh_pkg::rgh_bin_t           bo
);
  import rgh_pkg::*;

  localparam logic [6:0] TOP_BIN = 7'(MAX_BINS - 1);

  logic               v1, v2, v3;
  logic [SUM_W-1:0]   sum_c, sum1;
  logic [27:0]        grey_prod;
  logic [GREY_W-1:0]  grey2;
  logic [23:0]        bin_prod;
  logic [6:0]         bin_raw;
  logic [BIN_W-1:0]   bin3;

  assign sum_c = SUM_W'(red) * SUM_W'(W_RED) + SUM_W'(green) * SUM_W'(W_GREEN)
               + SUM_W'(blue) * SUM_W'(W_BLUE);
  assign grey_prod = 28'(sum1) * 28'(GREY_MUL);
  assign bin_prod  = 24'(grey2) * 24'(recip);
  assign bin_raw   = bin_prod[RECIP_SHIFT +: 7];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    sum1  <= sum_c;
    grey2 <= grey_prod[GREY_SHIFT +: GREY_W];
    bin3  <= (bin_raw > TOP_BIN) ? BIN_W'(TOP_BIN) : BIN_W'(bin_raw);
  end

  assign bo.busy  = v1 | v2 | v3;
  assign bo.valid = v3;
  assign bo.bin   = bin3;

endmodule

// ===== hw/rtl/rgb_grey_histogram_core.sv =====
//------------------------------------------------------------------------------
// rgb_grey_histogram_core
// Grey-level histogram of an RGB pixel stream, read out and cleared per image.
//------------------------------------------------------------------------------
// Throughput: one pixel beat per cycle while counting and the divider is idle; the
//   bin store's read-modify-write with one-entry forwarding sets that rate.
// Pixel path: sum, grey and bin registers, then the store read-modify-write. After the last
//   pixel the pipe drains; each bin is then read and loaded, each unused entry zeroed.
// Reset (rst, synchronous): bin width 16, then a clearing pass over every store entry;
//   a bin width write stalls pixel input while the divider runs.
//------------------------------------------------------------------------------
`include "rgb_grey_histogram_core_defines.svh"

module rgb_grey_histogram_core #(
  parameter int MAX_BINS   = 64,
  parameter int MAX_PIXELS = 1048576
) (
  input  logic        clk,
  input  logic        rst,
  // pixel input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic        s_tlast,   // last_pixel
  // bin readout
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // bin_index [5:0], bin_count [26:6], zero [31:27]
  output logic        m_tlast,   // last_bin
  // bin width register
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata
);
  import rgh_pkg::*;

  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam logic [AW-1:0]    LAST_ADDR = AW'(MAX_BINS - 1);
  localparam logic [CNT_W-1:0] COUNT_CAP =
    (MAX_PIXELS > 2097151) ? {CNT_W{1'b1}} : CNT_W'(MAX_PIXELS);

  rgh_recip_t rc;
  rgh_bin_t   bo;
  rgh_state_t state, state_next;

  // sweep counter for clearing and readout
  logic [AW-1:0] cnt, cnt_next;

  // stage 4: read data returns, count is modified and written back
  logic          v4;
  logic [AW-1:0] a4;
  // last write, forwarded when the next pixel hits the same bin
  logic             wb_v;
  logic [AW-1:0]    wb_a;
  logic [CNT_W-1:0] wb_d;
  logic [CNT_W-1:0] cur, inc;

  // memory ports
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [CNT_W-1:0] ram_wdata, ram_rdata;

  // output register
  logic             out_valid;
  logic [BIN_W-1:0] out_idx;
  logic [CNT_W-1:0] out_cnt;
  logic             out_last;
  logic             load;

  logic [AW-1:0] last_idx;
  logic          pix_acc;

  assign last_idx = rc.last_bin[AW-1:0];
  assign s_tready = (state == ST_RUN) && !rc.busy;
  assign pix_acc  = s_tvalid && s_tready;

  rgh_recip #(.MAX_BINS(MAX_BINS)) u_recip (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rc        (rc)
  );

  rgh_pixpipe #(.MAX_BINS(MAX_BINS)) u_pix (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix_acc),
    .red      (s_tdata[7:0]),
    .green    (s_tdata[15:8]),
    .blue     (s_tdata[23:16]),
    .recip    (rc.recip),
    .bo       (bo)
  );

  rgh_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BINS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // RAM is read-first: a read in the cycle of the previous write is stale
  assign cur = (wb_v && wb_a == a4) ? wb_d : ram_rdata;
  assign inc = (cur < COUNT_CAP) ? cur + CNT_W'(1) : cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      v4    <= 1'b0;
      wb_v  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      v4    <= bo.valid;
      wb_v  <= v4;
    end
  end

  always_ff @(posedge clk) begin
    a4   <= bo.bin[AW-1:0];
    wb_a <= a4;
    wb_d <= inc;
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ram_we     = 1'b0;
    ram_waddr  = cnt;
    ram_wdata  = '0;
    ram_raddr  = cnt;
    load       = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (cnt == LAST_ADDR) begin
          cnt_next   = '0;
          state_next = ST_RUN;
        end else begin
          cnt_next = cnt + AW'(1);
        end
      end
      ST_RUN, ST_FLUSH: begin
        ram_raddr = bo.bin[AW-1:0];
        ram_we    = v4;
        ram_waddr = a4;
        ram_wdata = inc;
        if (state == ST_RUN) begin
          if (pix_acc && s_tlast) begin
            state_next = ST_FLUSH;
          end
        end else if (!bo.busy && !v4) begin
          state_next = ST_DUMP_RD;
        end
      end
      ST_DUMP_RD: begin
        if (cnt > last_idx) begin
          // unused entry: zero it, nothing to emit
          ram_we = 1'b1;
          if (cnt == LAST_ADDR) begin
            cnt_next   = '0;
            state_next = ST_RUN;
          end else begin
            cnt_next = cnt + AW'(1);
          end
        end else if (!out_valid || m_tready) begin
          ram_we     = 1'b1;
          state_next = ST_DUMP_LD;
        end
      end
      ST_DUMP_LD: begin
        load = 1'b1;
        if (cnt == LAST_ADDR) begin
          cnt_next   = '0;
          state_next = ST_RUN;
        end else begin
          cnt_next   = cnt + AW'(1);
          state_next = ST_DUMP_RD;
        end
      end
      default: begin
        state_next = ST_CLEAR;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_valid && m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_idx  <= BIN_W'(cnt);
      out_cnt  <= ram_rdata;
      out_last <= (cnt == last_idx);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_cnt, out_idx};
  assign m_tlast  = out_last;

  `RGH_ASSERT_IMP(a_ld_out_free, state == ST_DUMP_LD, !out_valid, "readout overran output beat")
  `RGH_ASSERT_IMP(a_pix_wr_state, v4, state == ST_RUN || state == ST_FLUSH, "pixel write outside count")
  `RGH_ASSERT_IMP(a_dump_drained, state == ST_DUMP_RD, !bo.busy && !v4, "readout with pixels in flight")
  `RGH_ASSERT_NXT(a_last_flush, pix_acc && s_tlast, state == ST_FLUSH, "last pixel did not start flush")

endmodule

// ===== tb/rgb_grey_histogram_core_tb.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// rgb_grey_histogram_core_tb
// Drives RGB pixel images into the histogram core under random bin sizes and
// random stalls on both streams. A scoreboard bins every accepted pixel the way
// the core should and checks each bin beat of the readout, field by field.
//------------------------------------------------------------------------------
module rgb_grey_histogram_core_tb;
  import rgh_pkg::*;

  localparam int MAX_BINS     = 64;
  localparam int MAX_PIXELS   = 1048576;
  localparam int COUNT_TOP    = (1 << CNT_W) - 1;
  localparam int COUNT_CAP    = (MAX_PIXELS < COUNT_TOP) ? MAX_PIXELS : COUNT_TOP;
  localparam int GREY_LEVELS  = 256;
  localparam int GREY_DIV     = 100;
  localparam int SETTLE       = 120;     // pipe + full sweep of the store + divider
  localparam int HOLD_CYCLES  = 300;     // long readout stall, fills the core up
  localparam int PHASE_ITEMS  = 14;      // pixels per random phase, roughly
  localparam int MAX_REPORTS  = 40;      // keep the log short on a bad run
  localparam int LIMIT        = 600000;  // watchdog bound on the whole run

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [23:0]         s_tdata;   // red [7:0], green [15:8], blue [23:16]
  logic                s_tlast;   // last_pixel
  logic                m_tvalid;
  logic                m_tready;
  logic [31:0]         m_tdata;   // bin_index [5:0], bin_count [26:6], zero [31:27]
  logic                m_tlast;   // last_bin
  logic                cfg_we;
  logic [CFG_W-1:0]    cfg_wdata;

  // calm and hold_requests are shared by the pixel driver and the readout sink
  bit                  calm;           // no idling on either side once set
  int unsigned         hold_requests;  // bumped by the driver to ask for a long stall
  int unsigned         cycle_count;

  typedef struct {
    logic [BIN_W-1:0] bin_idx;
    logic [CNT_W-1:0] bin_cnt;
    logic             final_bin;
  } bin_beat_t;

  // Per-image grey-level histogram with its own copy of the bin width; every
  // last_pixel beat turns the tallies into the bin beats due on the output.
  class histogram_scoreboard;
    logic [CFG_W-1:0] bin_width;
    int unsigned      tally[MAX_BINS];
    bin_beat_t        bins_due[$];
    int               errors;

    function new();
      bin_width = CFG_W'(BIN_SIZE_RESET);
      foreach (tally[k]) tally[k] = 0;
      errors = 0;
    endfunction

    function void set_bin_width(logic [CFG_W-1:0] v);
      bin_width = v;
    endfunction

    // out-of-range sizes clamp to the legal span
    function int unsigned eff_size();
      int unsigned s;
      s = bin_width;
      if (s < BIN_SIZE_MIN) s = BIN_SIZE_MIN;
      if (s > BIN_SIZE_MAX) s = BIN_SIZE_MAX;
      return s;
    endfunction

    function int unsigned pending();
      return bins_due.size();
    endfunction

    function void note_pixel(logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
                             logic [COMP_W-1:0] b, logic last);
      int unsigned s, nbins, grey, bin;
      bin_beat_t   beat;
      s     = eff_size();
      nbins = (GREY_LEVELS + s - 1) / s;
      if (nbins > MAX_BINS) nbins = MAX_BINS;
      grey  = (W_RED * r + W_GREEN * g + W_BLUE * b) / GREY_DIV;
      bin   = grey / s;
      if (bin >= nbins) bin = nbins - 1;   // too many bins: fold into the top one
      if (tally[bin] < COUNT_CAP) tally[bin]++;
      if (last) begin
        // readout with the size in force now; the whole store clears
        for (int unsigned k = 0; k < nbins; k++) begin
          beat.bin_idx   = BIN_W'(k);
          beat.bin_cnt   = CNT_W'(tally[k]);
          beat.final_bin = (k == nbins - 1);
          bins_due.push_back(beat);
        end
        foreach (tally[k]) tally[k] = 0;
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_bin(logic [BIN_W-1:0] idx, logic [CNT_W-1:0] cnt, logic [4:0] pad,
                   logic final_bin);
      bin_beat_t want;
      if (bins_due.size() == 0) begin
        report($sformatf("bin beat idx %0d count %0d with nothing due", idx, cnt));
      end else begin
        want = bins_due.pop_front();
        if (idx !== want.bin_idx)
          report($sformatf("bin_index %0d, want %0d", idx, want.bin_idx));
        if (cnt !== want.bin_cnt)
          report($sformatf("bin %0d count %0d, want %0d", want.bin_idx, cnt, want.bin_cnt));
        if (final_bin !== want.final_bin)
          report($sformatf("bin %0d last_bin %b, want %b", want.bin_idx, final_bin,
                           want.final_bin));
        if (pad !== 5'd0)
          report($sformatf("bin %0d pad bits %b, want zero", want.bin_idx, pad));
      end
    endtask
  endclass

  histogram_scoreboard sb;

  rgb_grey_histogram_core #(
    .MAX_BINS   (MAX_BINS),
    .MAX_PIXELS (MAX_PIXELS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one pixel beat; entered and left at a falling edge. tvalid stays up
  // on return so back-to-back beats go without a bubble.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_tdata  = {b, g, r};
    s_tlast  = last;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(r, g, b, last);
    @(negedge clk);
  endtask

  // Idle point for a register write: every bin beat due is out, then the
  // core gets time to finish its sweep of unused entries and any pixel still
  // in the pipe.
  task automatic settle();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_bin_width(input logic [CFG_W-1:0] v);
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(posedge clk);
    sb.set_bin_width(v);
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Readout side: accepted bin beats go to the scoreboard.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_bin(m_tdata[5:0], m_tdata[26:6], m_tdata[31:27], m_tlast);
  end

  // Readout tready: random stall bursts, plus one long hold when asked for.
  initial begin
    int unsigned holds_done, n;
    holds_done = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        // long hold: sender keeps pushing, core backs up into s_tready
        m_tready = 1'b0;
        n = 0;
        while (n < HOLD_CYCLES) begin
          @(negedge clk);
          n++;
        end
        holds_done++;
      end
      if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("rgb_grey_histogram_core_tb: FAIL");
    $finish;
  end

  initial begin
    int unsigned      ph, len, k, phase_items, s, v;
    logic [7:0]       r, g, b;
    logic             closes;
    logic [CFG_W-1:0] sizes[8];

    sb            = new();
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tlast       = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    calm          = 1'b0;
    hold_requests = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed ---
    // reset size 16: black, white, both sides of a bin edge, pure primaries
    send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd15,  8'd15,  8'd15,  1'b0);
    send_pixel(8'd16,  8'd16,  8'd16,  1'b0);
    send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
    send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
    send_pixel(8'd0,   8'd0,   8'd255, 1'b1);
    send_pixel(8'd1,   8'd2,   8'd3,   1'b1);   // one-pixel image

    // size changed mid-image; zero clamps up to the minimum
    send_pixel(8'd200, 8'd10,  8'd90,  1'b0);
    settle();
    write_bin_width(9'd0);
    send_pixel(8'd3,   8'd3,   8'd3,   1'b0);
    send_pixel(8'd4,   8'd4,   8'd4,   1'b0);
    send_pixel(8'd170, 8'd85,  8'd51,  1'b1);

    // all-ones size clamps down to one bin
    settle();
    write_bin_width(9'd511);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd77,  8'd88,  8'd99,  1'b0);
    send_pixel(8'd0,   8'd0,   8'd0,   1'b1);

    // just below the minimum, just above the maximum
    settle();
    write_bin_width(9'd3);
    send_pixel(8'd254, 8'd254, 8'd254, 1'b1);
    settle();
    write_bin_width(9'd257);
    send_pixel(8'd128, 8'd64,  8'd32,  1'b1);

    // --- random phases, one bin size each ---
    sizes = '{9'd4, 9'd256, 9'd5, 9'd0, 9'd16, 9'd7, 9'd100, 9'd0};
    sizes[7] = CFG_W'($urandom_range(0, 511));
    for (ph = 0; ph < 8; ph++) begin
      if (ph == 7) calm = 1'b1;   // last stretch runs flat out
      settle();
      write_bin_width(sizes[ph]);
      if (ph == 2) hold_requests++;
      s = sb.eff_size();
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        len = $urandom_range(1, 8);
        // the last image of a phase may stay open across the next size write
        closes = (phase_items + len < PHASE_ITEMS) || (ph == 7) || ($urandom_range(0, 1) == 1);
        for (k = 0; k < len; k++) begin
          case ($urandom_range(0, 9))
            0: begin
              r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
              g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
              b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            1: begin
              // grey level right on or just under a bin edge
              v = s * $urandom_range(1, (GREY_LEVELS + s - 1) / s) - $urandom_range(0, 1);
              if (v > 255) v = 255;
              r = 8'(v);
              g = 8'(v);
              b = 8'(v);
            end
            default: begin
              r = 8'($urandom);
              g = 8'($urandom);
              b = 8'($urandom);
            end
          endcase
          send_pixel(r, g, b, closes && (k == len - 1));
        end
        phase_items += len;
      end
    end

    settle();
    if (sb.errors == 0)
      $display("rgb_grey_histogram_core_tb: PASS");
    else
      $display("rgb_grey_histogram_core_tb: FAIL");
    $finish;
  end

endmodule
